// ----- design/sm3_pkg.sv -----
// ----------------------------------------------------------------------------
// SM3 package
// Shared constants, request type and round helper functions.
// ----------------------------------------------------------------------------
package sm3_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [31:0] TjLow  = 32'h79cc4519;
  localparam logic [31:0] TjHigh = 32'h7a879d8a;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic [5:0]  LenPos  = 6'd56;

  localparam logic [255:0] IvValue = {
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       eom;
  } req_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] t;
    t = {v, v} << n;
    return t[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

// ----- design/sm3_front.sv -----
// ----------------------------------------------------------------------------
// SM3 front end
// Accept input requests, drop empty ones, queue the rest for the engine.
// ----------------------------------------------------------------------------
module sm3_front #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        data_byte_i,
  input  logic              has_byte_i,
  input  logic              end_of_message_i,
  input  logic              valid_i,
  output logic              ready_o,
  output sm3_pkg::req_t     req_o,
  output logic              req_valid_o,
  input  logic              req_ready_i
);
  import sm3_pkg::*;

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  req_t            mem_q [Depth];
  logic [Aw-1:0]   wr_q, rd_q;
  logic [Aw:0]     cnt_q;
  logic            push, pop, keep;

  assign ready_o     = (cnt_q != Depth[Aw:0]);
  assign keep        = has_byte_i | end_of_message_i;
  assign push        = valid_i & ready_o & keep;
  assign req_valid_o = (cnt_q != '0);
  assign pop         = req_valid_o & req_ready_i;
  assign req_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{data: data_byte_i, has_byte: has_byte_i, eom: end_of_message_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end

endmodule

// ----- design/sm3_engine.sv -----
// ----------------------------------------------------------------------------
// SM3 engine
// Gather bytes into message words, pad, run 64 rounds per block, emit digest.
// ----------------------------------------------------------------------------
module sm3_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sm3_pkg::req_t     req_i,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic [31:0]       digest_word_o,
  output logic [2:0]        word_index_o,
  output logic              last_word_o,
  output logic              valid_o,
  input  logic              ready_i
);
  import sm3_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRound = 3'd1;
  localparam logic [2:0] StPad = 3'd2;
  localparam logic [2:0] StLen = 3'd3;
  localparam logic [2:0] StOut = 3'd4;

  logic [2:0]   st_q, st_d;
  logic [31:0]  w_q [16];
  logic [31:0]  r_q [8];
  logic [31:0]  v_q [8];
  logic [5:0]   fill_q;
  logic [60:0]  total_q;
  logic [5:0]   rnd_q;
  logic         fin_q;
  logic         eom_q;
  logic         done_q;
  logic [2:0]   oidx_q;
  logic         out_v_q;

  logic [31:0]  a12, ss1, ss2, ffv, ggv, tt1, tt2, wn, tj;
  logic [31:0]  wj, wj4;
  logic [63:0]  bitlen;
  logic         take;

  assign req_ready_o = (st_q == StIdle);
  assign take        = req_valid_i & req_ready_o;
  assign bitlen      = {total_q, 3'b000};

  assign wj  = w_q[0];
  assign wj4 = w_q[4];
  assign tj  = (rnd_q < 6'd16) ? TjLow : TjHigh;
  assign a12 = rotl(r_q[0], 5'd12);
  assign ss1 = rotl(a12 + r_q[4] + rotl(tj, rnd_q[4:0]), 5'd7);
  assign ss2 = ss1 ^ a12;
  assign ffv = (rnd_q < 6'd16) ? (r_q[0] ^ r_q[1] ^ r_q[2])
             : ((r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]));
  assign ggv = (rnd_q < 6'd16) ? (r_q[4] ^ r_q[5] ^ r_q[6])
             : ((r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]));
  assign tt1 = ffv + r_q[3] + ss2 + (wj ^ wj4);
  assign tt2 = ggv + r_q[7] + ss1 + wj;
  assign wn  = p1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15)) ^ rotl(w_q[3], 5'd7) ^ w_q[10];

  assign valid_o       = out_v_q;
  assign digest_word_o = v_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd7);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle:  if (take && req_i.has_byte && fill_q == 6'd63) st_d = StRound;
               else if (take && req_i.eom) st_d = StPad;
      StRound: if (rnd_q == 6'd63) st_d = done_q ? StOut : (eom_q ? StPad : StIdle);
      StPad:   st_d = (fill_q == 6'd63) ? StRound
                    : (fill_q == LenPos - 6'd1) ? StLen : StPad;
      StLen:   st_d = StRound;
      StOut:   if (ready_i && oidx_q == 3'd7) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  logic [31:0] w_d [16];
  logic [5:0]  pad_pos;

  always_comb begin
    w_d = w_q;
    pad_pos = fill_q;
    unique case (st_q)
      StIdle: if (take && req_i.has_byte) begin
        w_d[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] = req_i.data;
      end
      StPad: begin
        w_d[pad_pos[5:2]][{~pad_pos[1:0], 3'b000} +: 8] = (fin_q) ? 8'h00 : PadByte;
      end
      StLen: begin
        w_d[14] = bitlen[63:32];
        w_d[15] = bitlen[31:0];
      end
      StRound: begin
        for (int i = 0; i < 15; i++) w_d[i] = w_q[i+1];
        w_d[15] = wn;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      fill_q  <= '0;
      total_q <= '0;
      rnd_q   <= '0;
      fin_q   <= 1'b0;
      eom_q   <= 1'b0;
      done_q  <= 1'b0;
      oidx_q  <= '0;
      out_v_q <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= IvValue[32*(7-i) +: 32];
        r_q[i] <= '0;
      end
    end else begin
      st_q <= st_d;
      unique case (st_q)
        StIdle: if (take) begin
          if (req_i.has_byte) begin
            fill_q  <= fill_q + 1'b1;
            total_q <= total_q + 1'b1;
            if (fill_q == 6'd63) begin
              for (int i = 0; i < 8; i++) r_q[i] <= v_q[i];
              rnd_q <= '0;
            end
          end
          if (req_i.eom) begin
            eom_q <= 1'b1;
            fin_q <= 1'b0;
          end
        end
        StPad: begin
          // first pad cycle writes 0x80, later ones zero
          fin_q  <= 1'b1;
          fill_q <= fill_q + 1'b1;
          if (fill_q == 6'd63) begin
            for (int i = 0; i < 8; i++) r_q[i] <= v_q[i];
            rnd_q <= '0;
          end
        end
        StLen: begin
          fill_q <= '0;
          for (int i = 0; i < 8; i++) r_q[i] <= v_q[i];
          rnd_q  <= '0;
          done_q <= 1'b1;
        end
        StRound: begin
          r_q[3] <= r_q[2];
          r_q[2] <= rotl(r_q[1], 5'd9);
          r_q[1] <= r_q[0];
          r_q[0] <= tt1;
          r_q[7] <= r_q[6];
          r_q[6] <= rotl(r_q[5], 5'd19);
          r_q[5] <= r_q[4];
          r_q[4] <= p0(tt2);
          rnd_q  <= rnd_q + 1'b1;
          if (rnd_q == 6'd63) begin
            v_q[0] <= v_q[0] ^ tt1;
            v_q[1] <= v_q[1] ^ r_q[0];
            v_q[2] <= v_q[2] ^ rotl(r_q[1], 5'd9);
            v_q[3] <= v_q[3] ^ r_q[2];
            v_q[4] <= v_q[4] ^ p0(tt2);
            v_q[5] <= v_q[5] ^ r_q[4];
            v_q[6] <= v_q[6] ^ rotl(r_q[5], 5'd19);
            v_q[7] <= v_q[7] ^ r_q[6];
            fill_q <= '0;
            if (done_q) begin
              out_v_q <= 1'b1;
              oidx_q  <= '0;
            end
          end
        end
        StOut: if (ready_i) begin
          oidx_q <= oidx_q + 1'b1;
          if (oidx_q == 3'd7) begin
            out_v_q <= 1'b0;
            fill_q  <= '0;
            total_q <= '0;
            fin_q   <= 1'b0;
            eom_q   <= 1'b0;
            done_q  <= 1'b0;
            for (int i = 0; i < 8; i++) v_q[i] <= IvValue[32*(7-i) +: 32];
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- design/sm3_hash_core.sv -----
// SM3 hash core. One message byte per request; a request with end set pads
// the message and returns eight digest words, word 0 first. Bytes are taken
// into a four-entry queue; the engine drains one byte per cycle while idle
// and runs the 64-round compression at one round per cycle, taking no new
// bytes until a full block is compressed. Finishing pads, writes the length
// and runs one or two compressions, then outputs the eight digest words.
// ----------------------------------------------------------------------------
// SM3 hash core top level
// Front queue and compression engine.
// ----------------------------------------------------------------------------
module sm3_hash_core #(
  parameter int unsigned QueueDepth = sm3_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  input  logic        valid_i,
  output logic        ready_o,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o,
  output logic        valid_o,
  input  logic        ready_i
);
  import sm3_pkg::*;

  req_t req;
  logic req_valid, req_ready;

  sm3_front #(.Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni, .data_byte_i, .has_byte_i, .end_of_message_i,
    .valid_i, .ready_o,
    .req_o(req), .req_valid_o(req_valid), .req_ready_i(req_ready)
  );

  sm3_engine u_engine (
    .clk_i, .rst_ni,
    .req_i(req), .req_valid_i(req_valid), .req_ready_o(req_ready),
    .digest_word_o, .word_index_o, .last_word_o, .valid_o, .ready_i
  );

endmodule

// ----- design/sm3_checker.sv -----
// ----------------------------------------------------------------------------
// SM3 port checker
// Port-level properties of the digest stream.
// ----------------------------------------------------------------------------
module sm3_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_o,
  input logic        ready_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (last_word_o == (word_index_o == 3'd7)))
    else $error("last flag mismatch");

  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && ready_i && !last_word_o) |=> (valid_o && word_index_o == $past(word_index_o) + 3'd1))
    else $error("digest words not contiguous");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> (valid_o && $stable(digest_word_o) && $stable(word_index_o)))
    else $error("stalled word changed");

  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && ready_i && last_word_o) |=> !valid_o)
    else $error("output after last word");

endmodule

bind sm3_hash_core sm3_checker u_sm3_checker (.*);
